[hw/rtl/psi_pkg.sv]
`default_nettype none
package psi_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW = 8;
  localparam int unsigned AtanN = 32;

  localparam logic [DataW-1:0] GainQ30 = 32'd652032874;
  localparam logic signed [33:0] OneQ30 = 34'sd1073741824;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_ENDS,
    ST_WAIT_ENDS,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SEG_RD,
    ST_SEG_LATCH,
    ST_MOD,
    ST_DIV,
    ST_CORDIC,
    ST_COMB_MUL,
    ST_COMB_ADD,
    ST_OUT
  } state_e;

  // Datapath commands issued by the controller.
  typedef struct packed {
    logic start;
    logic rd_ends;
    logic ends_chk;
    logic srch_rd;
    logic srch_cmp;
    logic seg_rd;
    logic seg_latch;
    logic mod_step;
    logic div_step;
    logic cordic_step;
    logic comb_mul;
    logic comb_add;
    logic out_load;
  } psi_cmd_t;

  // Status back to the controller.
  typedef struct packed {
    logic clamped;
    logic srch_done;
    logic zero_width;
    logic mod_done;
    logic div_done;
    logic cordic_done;
  } psi_sts_t;

  function automatic logic [DataW-1:0] atan_turn(input logic [4:0] i);
    logic [DataW-1:0] r;
    begin
      unique case (i)
        5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051E;
        5'd2: r = 32'h09FB385B; 5'd3: r = 32'h051111D4;
        5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
        5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55;
        5'd8: r = 32'h0028BE53; 5'd9: r = 32'h00145F2F;
        5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
        5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
        5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
        5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
        5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
        5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
        5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
        5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
        5'd30: r = 32'h00000001; default: r = 32'h00000000;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

[hw/rtl/piecewise_sine_interpolator.sv]
`default_nettype none
// Piecewise sine interpolator.
// Input channel (in_valid / in_stall) carries one transaction per item:
// command_i selects load (write a breakpoint) or evaluate (query x).
// Loads finish in the accept cycle and produce no result. An evaluate
// runs through a fixed sequencer: end-breakpoint read and clamp check,
// binary search (skipped when clamped, else up to 8 probes), segment
// read and latch, bit-serial remainder, restoring divider, CORDIC
// rotation, then combine and output; a zero-width segment skips
// remainder, divider and CORDIC. The input is freed as out_valid rises.
// Output channel (out_valid / out_stall) holds result_value_o and
// segment_index_o in a register until taken. The input stays stalled
// while an evaluate is in flight and while its finished result waits
// behind a held one; a held result does not block loads.
// segment_count_wdata is to be written with segment_count_we only when
// idle, by the user; the block itself does not enforce this.
// Reset clears the controller and output valid and sets the count to 1;
// breakpoint memory is undefined until loaded.
module piecewise_sine_interpolator #(
  parameter int unsigned MAX_POINTS   = 256,
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               command_i,
  input  wire logic [7:0]         point_index_i,
  input  wire logic signed [31:0] x_value_i,
  input  wire logic [31:0]        y_value_i,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      result_value_o,
  output logic [7:0]              segment_index_o,
  input  wire logic               segment_count_we,
  input  wire logic [7:0]         segment_count_wdata
);
  import psi_pkg::*;

  psi_cmd_t cmd;
  psi_sts_t sts;
  logic [7:0] seg_cnt_q;
  logic out_valid_q;
  logic ctrl_stall;
  logic load;
  logic signed [31:0] res;
  logic [7:0] seg;
  logic signed [31:0] res_q;
  logic [7:0] seg_q;

  // Drop loads whose slot lies past the table.
  assign load = in_valid && !in_stall && command_i == CMD_LOAD
                && {24'd0, point_index_i} < 32'(MAX_POINTS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_cnt_q <= 8'd1;
      out_valid_q <= 1'b0;
    end else begin
      if (segment_count_we) seg_cnt_q <= segment_count_wdata;
      if (cmd.out_load) out_valid_q <= 1'b1;
      else if (!out_stall) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      res_q <= res;
      seg_q <= seg;
    end
  end

  psi_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid,
    .in_cmd_i  (command_i),
    .out_free_i(!out_valid_q || !out_stall),
    .sts_i     (sts),
    .in_stall  (ctrl_stall),
    .cmd_o     (cmd)
  );

  psi_dp #(
    .MAX_POINTS  (MAX_POINTS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i          (cmd),
    .load_i         (load),
    .point_index_i,
    .x_value_i,
    .y_value_i,
    .segment_count_i(seg_cnt_q),
    .sts_o          (sts),
    .result_o       (res),
    .segment_o      (seg)
  );

  assign in_stall = ctrl_stall;
  assign out_valid = out_valid_q;
  assign result_value_o = res_q;
  assign segment_index_o = seg_q;

endmodule
`default_nettype wire

[hw/rtl/psi_ctrl.sv]
`default_nettype none
module psi_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid,
  input  wire logic             in_cmd_i,
  input  wire logic             out_free_i,
  input  psi_pkg::psi_sts_t     sts_i,
  output logic                  in_stall,
  output psi_pkg::psi_cmd_t     cmd_o
);
  import psi_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid && in_cmd_i == CMD_EVAL) state_d = ST_RD_ENDS;
      end
      ST_RD_ENDS: state_d = ST_WAIT_ENDS;
      ST_WAIT_ENDS: state_d = sts_i.clamped ? ST_SEG_RD : ST_SRCH_RD;
      ST_SRCH_RD: state_d = sts_i.srch_done ? ST_SEG_RD : ST_SRCH_CMP;
      ST_SRCH_CMP: state_d = ST_SRCH_RD;
      ST_SEG_RD: state_d = ST_SEG_LATCH;
      ST_SEG_LATCH: state_d = ST_MOD;
      ST_MOD: begin
        if (sts_i.zero_width) state_d = ST_COMB_MUL;
        else if (sts_i.mod_done) state_d = ST_DIV;
      end
      ST_DIV: if (sts_i.div_done) state_d = ST_CORDIC;
      ST_CORDIC: if (sts_i.cordic_done) state_d = ST_COMB_MUL;
      ST_COMB_MUL: state_d = ST_COMB_ADD;
      ST_COMB_ADD: if (out_free_i) state_d = ST_OUT;
      ST_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: cmd_o.start = in_valid && in_cmd_i == CMD_EVAL;
      ST_RD_ENDS: cmd_o.rd_ends = 1'b1;
      ST_WAIT_ENDS: cmd_o.ends_chk = 1'b1;
      ST_SRCH_RD: cmd_o.srch_rd = 1'b1;
      ST_SRCH_CMP: cmd_o.srch_cmp = 1'b1;
      ST_SEG_RD: cmd_o.seg_rd = 1'b1;
      ST_SEG_LATCH: cmd_o.seg_latch = 1'b1;
      ST_MOD: cmd_o.mod_step = 1'b1;
      ST_DIV: cmd_o.div_step = 1'b1;
      ST_CORDIC: cmd_o.cordic_step = 1'b1;
      ST_COMB_MUL: cmd_o.comb_mul = 1'b1;
      ST_COMB_ADD: cmd_o.comb_add = 1'b1;
      ST_OUT: cmd_o.out_load = 1'b1;
      default: cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/psi_dp.sv]
`default_nettype none
module psi_dp #(
  parameter int unsigned MAX_POINTS   = 256,
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  psi_pkg::psi_cmd_t        cmd_i,
  input  wire logic                load_i,
  input  wire logic [7:0]          point_index_i,
  input  wire logic signed [31:0]  x_value_i,
  input  wire logic [31:0]         y_value_i,
  input  wire logic [7:0]          segment_count_i,
  output psi_pkg::psi_sts_t        sts_o,
  output logic signed [31:0]       result_o,
  output logic [7:0]               segment_o
);
  import psi_pkg::*;

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(CORDIC_STEPS + 1);

  // Two-port memories: x and y breakpoints.
  logic [31:0] mem_x [MAX_POINTS];
  logic [31:0] mem_y [MAX_POINTS];
  logic [AW-1:0] ra_q, rb_q;
  logic [AW-1:0] ra_d, rb_d;
  logic [31:0] xa_q, xb_q, ya_q, yb_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      mem_x[AW'(point_index_i)] <= x_value_i;
      mem_y[AW'(point_index_i)] <= y_value_i;
    end
    xa_q <= mem_x[ra_d];
    ya_q <= mem_y[ra_d];
    xb_q <= mem_x[rb_d];
    yb_q <= mem_y[rb_d];
  end

  // Effective count, limited to 1..MAX_POINTS-1.
  logic [AW:0] n_eff;
  always_comb begin
    n_eff = 32'(segment_count_i) > 32'(MAX_POINTS - 1)
        ? (AW+1)'(MAX_POINTS - 1)
        : (AW+1)'(segment_count_i);
    if (segment_count_i == 8'd0) n_eff = (AW+1)'(1);
  end

  logic [AW:0] n_q, lo_q, hi_q, idx_q;
  logic [AW:0] mid;
  logic signed [31:0] xq_q;
  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  // Segment operands.
  logic signed [33:0] w_q;
  logic signed [34:0] u_q;
  logic [31:0] y0_q, y1_q;
  logic [35:0] m_q, r_q;
  logic [6:0] cnt_q;
  logic [5:0] mcnt_q;
  logic [63:0] num_q;
  logic [31:0] quo_q;
  logic [33:0] rem_q;
  logic signed [34:0] cx_q, cy_q, z_q;
  logic signed [33:0] s_q;
  logic signed [65:0] prod_q;
  logic signed [31:0] res_q;
  logic [31:0] mem_y0_q;

  always_comb begin
    ra_d = ra_q;
    rb_d = rb_q;
    if (cmd_i.start) begin
      ra_d = '0;
      rb_d = n_eff[AW-1:0];
    end else if (cmd_i.srch_rd) begin
      ra_d = mid[AW-1:0];
    end else if (cmd_i.seg_rd) begin
      ra_d = idx_q[AW-1:0];
      rb_d = AW'(idx_q + 1'b1);
    end
  end

  logic [35:0] r_sh;
  logic [34:0] rem_sh;
  logic [33:0] w_abs;
  logic signed [34:0] th;
  logic signed [34:0] dx, dy;
  logic [4:0] ci;
  logic [CW-1:0] cidx;
  assign w_abs = w_q[33:0];
  assign r_sh = {r_q[34:0], num_q[63]};
  assign rem_sh = {rem_q, num_q[63]};
  assign ci = cnt_q[4:0];
  assign dx = cy_q >>> ci;
  assign dy = cx_q >>> ci;
  assign cidx = cnt_q[CW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ra_q <= '0;
      rb_q <= '0;
    end else begin
      ra_q <= ra_d;
      rb_q <= rb_d;
    end
  end

  logic signed [33:0] d_y;
  logic [32:0] sum_y;
  logic [65:0] t_sum;
  logic [34:0] res_sh;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      xq_q <= x_value_i;
      n_q <= n_eff;
    end
    if (cmd_i.ends_chk) begin
      lo_q <= '0;
      hi_q <= n_q;
      if (xq_q < $signed(xa_q)) idx_q <= '0;
      else idx_q <= n_q - 1'b1;
    end
    if (cmd_i.srch_cmp) begin
      if ($signed(xa_q) > xq_q) hi_q <= mid;
      else lo_q <= mid;
    end
    if (cmd_i.srch_rd && sts_o.srch_done) idx_q <= lo_q;
    if (cmd_i.seg_latch) begin
      if ($signed(xb_q) < $signed(xa_q)) begin
        w_q <= -($signed({{2{xb_q[31]}}, xb_q}) - $signed({{2{xa_q[31]}}, xa_q}));
        u_q <= -(($signed({{3{xq_q[31]}}, xq_q}) <<< 1) - $signed({{3{xa_q[31]}}, xa_q})
                 - $signed({{3{xb_q[31]}}, xb_q}));
      end else begin
        w_q <= $signed({{2{xb_q[31]}}, xb_q}) - $signed({{2{xa_q[31]}}, xa_q});
        u_q <= ($signed({{3{xq_q[31]}}, xq_q}) <<< 1) - $signed({{3{xa_q[31]}}, xa_q})
               - $signed({{3{xb_q[31]}}, xb_q});
      end
      y0_q <= ya_q;
      y1_q <= (idx_q + 1'b1 == n_q) ? mem_y0_q : yb_q;
      cnt_q <= '0;
      s_q <= '0;
    end
    // Remainder |u| mod 4w, one bit of |u| per cycle over its 34 bits,
    // then fold the sign: r = (-|u|) mod 4w for a negative u.
    if (cmd_i.mod_step) begin
      if (cnt_q == 7'd0) begin
        m_q <= {w_abs, 2'b00};
        r_q <= '0;
        num_q <= {(u_q[34] ? 34'(-u_q) : 34'(u_q)), 30'd0};
        mcnt_q <= '0;
        cnt_q <= 7'd1;
      end else if (cnt_q == 7'd1) begin
        num_q <= num_q << 1;
        r_q <= (r_sh >= m_q) ? r_sh - m_q : r_sh;
        if (mcnt_q == 6'd33) cnt_q <= 7'd2;
        mcnt_q <= mcnt_q + 6'd1;
      end else begin
        if (u_q[34] && r_q != '0) r_q <= m_q - r_q;
        cnt_q <= 7'd6;
      end
    end
    if (cmd_i.div_step) begin
      if (cnt_q == 7'd6) begin
        num_q <= {r_q[33:0], 30'd0};
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= 7'd7;
      end else begin
        num_q <= num_q << 1;
        if (rem_sh >= {1'b0, w_abs}) begin
          rem_q <= 34'(rem_sh - {1'b0, w_abs});
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          rem_q <= rem_sh[33:0];
          quo_q <= {quo_q[30:0], 1'b0};
        end
        // Raise the CORDIC start flag when the divider finishes.
        cnt_q <= (cnt_q == 7'd70) ? 7'd64 : cnt_q + 7'd1;
      end
    end
    if (cmd_i.cordic_step) begin
      if (cnt_q[6]) begin
        cx_q <= {{3{1'b0}}, GainQ30};
        cy_q <= '0;
        z_q <= th;
        cnt_q <= '0;
      end else if (cidx < CW'(CORDIC_STEPS)) begin
        if (z_q >= 0) begin
          cx_q <= cx_q - dx; cy_q <= cy_q + dy;
          z_q <= z_q - $signed({3'b000, atan_turn(ci)});
        end else begin
          cx_q <= cx_q + dx; cy_q <= cy_q - dy;
          z_q <= z_q + $signed({3'b000, atan_turn(ci)});
        end
        cnt_q <= cnt_q + 7'd1;
      end
      if (cy_q > 35'(OneQ30)) s_q <= OneQ30;
      else if (cy_q < -35'(OneQ30)) s_q <= -OneQ30;
      else s_q <= cy_q[33:0];
    end
    if (cmd_i.comb_mul) prod_q <= d_y * s_q;
    if (cmd_i.comb_add) res_q <= (res_sh > 35'h7FFFFFFF) ? 32'h7FFFFFFF : res_sh[31:0];
  end

  // Shadow of breakpoint 0's y; it stands in for the last y.
  always_ff @(posedge clk_i) begin
    if (load_i && point_index_i == 8'd0) mem_y0_q <= y_value_i;
  end

  always_comb begin
    th = $signed({3'b000, quo_q});
    if (quo_q[31]) th = th - 35'sh100000000;
    if (th > 35'sd1073741824) th = 35'sh80000000 - th;
    if (th < -35'sd1073741824) th = -35'sh80000000 - th;
  end

  assign d_y = $signed({2'b00, y1_q}) - $signed({2'b00, y0_q});
  assign sum_y = {1'b0, y0_q} + {1'b0, y1_q};
  assign t_sum = ({33'd0, sum_y} << 30) + 66'(prod_q) + (66'd1 << 30);
  assign res_sh = t_sum[65:31];

  assign sts_o.clamped = (xq_q < $signed(xa_q)) || (xq_q >= $signed(xb_q));
  assign sts_o.srch_done = (hi_q - lo_q) <= 1;
  assign sts_o.zero_width = cmd_i.mod_step && cnt_q == 7'd0 && w_q == '0;
  assign sts_o.mod_done = cnt_q == 7'd2;
  assign sts_o.div_done = cnt_q == 7'd70;
  assign sts_o.cordic_done = !cnt_q[6] && cidx == CW'(CORDIC_STEPS);

  assign result_o = res_q;
  assign segment_o = 8'(idx_q);

endmodule
`default_nettype wire

[hw/rtl/psi_checker.sv]
`default_nettype none
module psi_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        command_i,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] result_value_o
);
  import psi_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(result_value_o))
    else $error("result dropped while stalled");

  a_load_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_stall && command_i == CMD_LOAD |=> !in_stall)
    else $error("load blocked input");

  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_stall && command_i == CMD_EVAL |=> in_stall)
    else $error("evaluate did not occupy block");

  a_no_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !result_value_o[31])
    else $error("negative result");

endmodule

bind piecewise_sine_interpolator psi_checker u_psi_checker (
  .clk_i, .rst_ni, .in_valid, .in_stall, .command_i,
  .out_valid, .out_stall, .result_value_o
);
`default_nettype wire

[test/piecewise_sine_interpolator_tb.sv]
`timescale 1ns / 1ps

module piecewise_sine_interpolator_tb;
  import psi_pkg::*;

  // Predicts the interpolated value for each evaluate transaction and keeps
  // the expected values in arrival order.
  class sine_scoreboard;
    bit signed [31:0] bp_x [256];
    bit [31:0] bp_y [256];
    bit [7:0] seg_count;
    bit [31:0] want_value [$];
    bit [7:0] want_segment [$];
    int unsigned errors;

    function new();
      seg_count = 1;
      errors = 0;
    endfunction

    function int unsigned pending();
      return want_value.size();
    endfunction

    function void set_count(bit [7:0] v);
      seg_count = v;
    endfunction

    // Sine of a turn fraction (2^32 = one turn), Q30.
    function longint cordic_sine(longint th);
      longint cx, cy, z, dx, dy;
      cx = 652032874;
      cy = 0;
      if (th > (64'sd1 <<< 30)) th = (64'sd1 <<< 31) - th;
      if (th < -(64'sd1 <<< 30)) th = -(64'sd1 <<< 31) - th;
      z = th;
      for (int i = 0; i < 24; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (z >= 0) begin
          cx -= dx; cy += dy; z -= longint'(atan_turn(5'(i)));
        end else begin
          cx += dx; cy -= dy; z += longint'(atan_turn(5'(i)));
        end
      end
      if (cy > 1073741824) cy = 1073741824;
      if (cy < -1073741824) cy = -1073741824;
      return cy;
    endfunction

    function void note_input(cmd_e cmd, bit [7:0] slot, bit signed [31:0] xv, bit [31:0] yv);
      int unsigned n, seg, lo, hi, mid;
      longint x, x0, x1, w, u, m, r, s, d, th;
      bit [63:0] ang, sum, t, res, y0, y1, ur, uw;
      if (cmd == CMD_LOAD) begin
        bp_x[slot] = xv;
        bp_y[slot] = yv;
        return;
      end
      n = (seg_count == 0) ? 1 : seg_count;
      x = xv;
      if (x < longint'(bp_x[0])) seg = 0;
      else if (x >= longint'(bp_x[n])) seg = n - 1;
      else begin
        lo = 0; hi = n;
        while (hi - lo > 1) begin
          mid = lo + ((hi - lo) >> 1);
          if (longint'(bp_x[mid]) > x) hi = mid; else lo = mid;
        end
        seg = lo;
      end
      x0 = bp_x[seg];
      x1 = bp_x[seg + 1];
      y0 = bp_y[seg];
      y1 = (seg + 1 == n) ? bp_y[0] : bp_y[seg + 1];
      w = x1 - x0;
      u = 2 * x - x0 - x1;
      s = 0;
      if (w != 0) begin
        if (w < 0) begin
          w = -w; u = -u;
        end
        m = 4 * w;
        r = u % m;
        if (r < 0) r += m;
        ur = r;
        uw = w;
        ang = (ur << 30) / uw;
        th = (ang >= 64'h8000_0000) ? longint'(ang) - 64'sd4294967296 : longint'(ang);
        s = cordic_sine(th);
      end
      d = longint'(y1) - longint'(y0);
      sum = y0 + y1;
      t = (sum << 30) + 64'(d * s);
      res = (t + (64'd1 << 30)) >> 31;
      if (res > 64'h7FFF_FFFF) res = 64'h7FFF_FFFF;
      want_value.push_back(res[31:0]);
      want_segment.push_back(seg[7:0]);
    endfunction

    function void check_result(bit [31:0] value, bit [7:0] segment);
      bit [31:0] ev;
      bit [7:0] es;
      if (want_value.size() == 0) begin
        $display("%0t: unexpected result value=%h segment=%0d", $time, value, segment);
        errors++;
        return;
      end
      ev = want_value.pop_front();
      es = want_segment.pop_front();
      if (value !== ev) begin
        $display("%0t: result_value expected %h actual %h", $time, ev, value);
        errors++;
      end
      if (segment !== es) begin
        $display("%0t: segment_index expected %0d actual %0d", $time, es, segment);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command_i = CMD_LOAD;
  logic [7:0] point_index_i = '0;
  logic signed [31:0] x_value_i = '0;
  logic [31:0] y_value_i = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] result_value_o;
  logic [7:0] segment_index_o;
  logic segment_count_we = 1'b0;
  logic [7:0] segment_count_wdata = '0;

  sine_scoreboard sb = new();
  bit send_burst;    // sender runs without gaps while set
  bit hold_output;   // ask the receiver for one long hold-off
  bit [7:0] active_count = 1;

  piecewise_sine_interpolator uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid(in_valid), .in_stall(in_stall),
    .command_i(command_i), .point_index_i(point_index_i),
    .x_value_i(x_value_i), .y_value_i(y_value_i),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_value_o(result_value_o), .segment_index_o(segment_index_o),
    .segment_count_we(segment_count_we), .segment_count_wdata(segment_count_wdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Nominal breakpoint grid: 256 slots spread over the whole signed range,
  // so any loaded table starts out sorted.
  function automatic logic signed [31:0] grid_x(int unsigned slot);
    return 32'(slot << 24) ^ 32'h8000_0000;
  endfunction

  // Offer one transaction after a gap; keep valid high when the gap is zero
  // so back-to-back transactions never lower and raise it in the same step.
  task automatic send_item(cmd_e cmd, logic [7:0] slot, logic signed [31:0] xv,
                           logic [31:0] yv);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    command_i <= cmd;
    point_index_i <= slot;
    x_value_i <= xv;
    y_value_i <= yv;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.note_input(cmd, slot, xv, yv);
  endtask

  // Drain all outstanding results, let the pipeline settle, then write
  // the segment count while the block is idle.
  task automatic write_count(logic [7:0] v);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    segment_count_we <= 1'b1;
    segment_count_wdata <= v;
    @(posedge clk_i);
    segment_count_we <= 1'b0;
    sb.set_count(v);
    active_count = (v == 0) ? 8'd1 : v;
  endtask

  // Pick a query mostly inside the active table, sometimes anywhere.
  task automatic send_query();
    int unsigned seg;
    logic signed [31:0] q;
    seg = $urandom_range(0, active_count - 1);
    case ($urandom_range(0, 9))
      0, 1: q = $urandom;
      2: q = grid_x(seg);
      default: q = grid_x(seg) + 32'($urandom_range(0, 32'h01FF_FFFF));
    endcase
    send_item(CMD_EVAL, 8'($urandom), q, $urandom);
  endtask

  task automatic send_random_load();
    logic [7:0] slot;
    slot = $urandom;
    if ($urandom_range(0, 9) == 0)
      send_item(CMD_LOAD, slot, $urandom, $urandom);
    else
      send_item(CMD_LOAD, slot, grid_x(slot) + 32'($urandom_range(0, 32'h00FF_FFFF)), $urandom);
  endtask

  // Receiver: random stall per result, with zero-stall stretches and one
  // long hold-off on request.
  initial begin
    int unsigned hold;
    bit quiet;
    quiet = 1'b0;
    forever begin
      if ($urandom_range(0, 15) == 0) quiet = !quiet;
      hold = quiet ? 0 : $urandom_range(0, 16);
      if (hold_output) begin
        hold = 3000;
        hold_output = 1'b0;
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
      sb.check_result(result_value_o, segment_index_o);
    end
  end

  initial begin
    #30_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [7:0] counts [8] = '{8'd1, 8'd0, 8'd255, 8'd2, 8'd7, 8'd128, 8'd0, 8'd0};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every slot so no evaluate ever reads an unwritten entry.
    send_burst = 1'b1;
    for (int i = 0; i < 256; i++) send_item(CMD_LOAD, 8'(i), grid_x(i), $urandom);
    send_burst = 1'b0;

    // Directed: single segment with extreme ends and values.
    write_count(8'd1);
    send_item(CMD_LOAD, 8'd0, 32'sh8000_0000, 32'h0000_0000);
    send_item(CMD_LOAD, 8'd1, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_EVAL, 8'hFF, 32'sh8000_0000, 32'hFFFF_FFFF);
    send_item(CMD_EVAL, 8'h00, 32'sh7FFF_FFFF, 32'h0);
    send_item(CMD_EVAL, 8'h5A, 32'sh0000_0000, 32'h0);
    send_item(CMD_LOAD, 8'd0, 32'sh0001_0000, 32'hFFFF_FFFF);
    send_item(CMD_EVAL, 8'h00, 32'sh8000_0000, 32'h0);   // below the first point
    send_item(CMD_EVAL, 8'h00, 32'sh7FFF_FFFF, 32'h0);   // at the last point
    // Zero-width segment.
    send_item(CMD_LOAD, 8'd1, 32'sh0001_0000, 32'h0000_0000);
    send_item(CMD_EVAL, 8'h00, 32'sh0001_0000, 32'h0);
    send_item(CMD_EVAL, 8'h00, 32'sh8000_0000, 32'h0);
    // Unsorted: negative width.
    send_item(CMD_LOAD, 8'd1, 32'shFFFF_0000, 32'h1234_5678);
    send_item(CMD_EVAL, 8'h00, 32'sh0000_8000, 32'h0);
    send_item(CMD_EVAL, 8'h00, 32'shFFF0_0000, 32'h0);
    send_item(CMD_LOAD, 8'd0, grid_x(0), 32'h0001_0000);
    send_item(CMD_LOAD, 8'd1, grid_x(1), 32'h0003_0000);

    // Random phases over several segment counts, extremes included.
    counts[6] = 8'($urandom_range(3, 254));
    counts[7] = 8'($urandom_range(3, 254));
    foreach (counts[p]) begin
      write_count(counts[p]);
      for (int k = 0; k < 140; k++) begin
        if (p == 3 && k == 40) hold_output = 1'b1;   // long receiver hold-off
        if ($urandom_range(0, 20) == 0) send_burst = !send_burst;
        if ($urandom_range(0, 9) < 7) send_query(); else send_random_load();
      end
      send_burst = 1'b0;
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/psi_pkg.sv
hw/rtl/psi_ctrl.sv
hw/rtl/psi_dp.sv
hw/rtl/piecewise_sine_interpolator.sv
hw/rtl/psi_checker.sv
test/piecewise_sine_interpolator_tb.sv
